// ----- design/pcba_pkg.sv -----
// Shared widths, codes and types of the per-CPU bitmap buffer allocator.
package pcba_pkg;

   // request and response field widths
   localparam int OPCODE_W = 1;
   localparam int CPU_W    = 6;
   localparam int ADDR_W   = 48;
   localparam int SHIFT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 12;

   // bitmap word geometry
   localparam int WORD_W      = 64;
   localparam int WORD_BITS_W = 6;

   // defaults for the top-level parameters
   localparam int NUM_CPUS_DEF         = 64;
   localparam int ENTRIES_PER_CPU_DEF  = 4096;
   localparam int CPU_REGION_SHIFT_DEF = 33;

   localparam logic [SHIFT_W-1:0] BUFFER_SHIFT_RESET = 5'd12;

   // control and status register port
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE  = 1'b0,
      CSR_BUFFER_SHIFT = 1'b1
   } csr_index_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_ADDR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ASUM,
      S_AWORD,
      S_FSUB,
      S_FDEC,
      S_FRD,
      S_FWR,
      S_RESP
   } state_type;

endpackage

// ----- design/pcba_req_if.sv -----
// Request channel of the allocator: allocate or free one buffer.
interface pcba_req_if;
   logic                           valid;
   logic                           ready;
   logic [pcba_pkg::OPCODE_W-1:0]  opcode;
   logic [pcba_pkg::CPU_W-1:0]     cpu;
   logic [pcba_pkg::ADDR_W-1:0]    buffer_address;

   modport source (output valid, opcode, cpu, buffer_address, input ready);
   modport sink   (input valid, opcode, cpu, buffer_address, output ready);
endinterface

// ----- design/pcba_rsp_if.sv -----
// Response channel of the allocator: status, granted address and bitmap index.
interface pcba_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pcba_pkg::STATUS_W-1:0]  status;
   logic [pcba_pkg::ADDR_W-1:0]    granted_address;
   logic [pcba_pkg::INDEX_W-1:0]   entry_index;

   modport source (output valid, status, granted_address, entry_index, input ready);
   modport sink   (input valid, status, granted_address, entry_index, output ready);
endinterface

// ----- design/per_cpu_bitmap_buffer_allocator_top.sv -----
// Per-CPU bitmap allocator: usage bitmap and full-word summary memories with RMW sequencer.
// Allocate: summary read, word read and write-back, response; no word read if none free.
// Free: address subtract, decode, read of both memories, write-back, then response;
//   a rejected address skips the read and the write-back.
// One request in flight; the next is taken in the cycle after the response register loads.
// Reset: a clearing pass writes zero to all NUM_CPUS*ceil(ENTRIES_PER_CPU/64) bitmap words,
//   one per cycle, with req_bus.ready low; csr writes still taken.
module per_cpu_bitmap_buffer_allocator_top #(
   parameter int NUM_CPUS         = pcba_pkg::NUM_CPUS_DEF,
   parameter int ENTRIES_PER_CPU  = pcba_pkg::ENTRIES_PER_CPU_DEF,
   parameter int CPU_REGION_SHIFT = pcba_pkg::CPU_REGION_SHIFT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pcba_req_if.sink                        req_bus,
   pcba_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [pcba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcba_pkg::ADDR_W-1:0]     csr_wdata
);

   localparam int WORDS_PER_CPU = (ENTRIES_PER_CPU + pcba_pkg::WORD_W - 1) / pcba_pkg::WORD_W;
   localparam int TOTAL_WORDS   = NUM_CPUS * WORDS_PER_CPU;
   localparam int MEM_AW        = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
   localparam int SUM_AW        = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int WIDX_W        = (WORDS_PER_CPU > 1) ? $clog2(WORDS_PER_CPU) : 1;
   localparam int IDX_W         = WIDX_W + pcba_pkg::WORD_BITS_W;
   localparam int AW            = pcba_pkg::ADDR_W;
   localparam int WW            = pcba_pkg::WORD_W;
   localparam int BW            = pcba_pkg::WORD_BITS_W;

   // storage
   logic [WW-1:0]            usage_mem   [TOTAL_WORDS];
   logic [WORDS_PER_CPU-1:0] summary_mem [NUM_CPUS];

   logic [WW-1:0]            usage_rd_ff;
   logic [WORDS_PER_CPU-1:0] summary_rd_ff;

   // memory controls
   logic                     usage_re, usage_we;
   logic [MEM_AW-1:0]        usage_raddr, usage_waddr;
   logic [WW-1:0]            usage_wdata;
   logic                     summary_re, summary_we;
   logic [SUM_AW-1:0]        summary_raddr, summary_waddr;
   logic [WORDS_PER_CPU-1:0] summary_wdata;

   // sequencer and datapath registers
   pcba_pkg::state_type      state_ff, state_in;
   logic [MEM_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]            base_ff, base_in;
   logic [pcba_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic [pcba_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [pcba_pkg::CPU_W-1:0] cpu_ff, cpu_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            off_ff, off_in;
   logic                     bad_ff, bad_in;
   logic [WIDX_W-1:0]        w_ff, w_in;
   logic [MEM_AW-1:0]        use_addr_ff, use_addr_in;
   logic [AW-1:0]            base_cpu_ff, base_cpu_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   pcba_pkg::status_type     status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [pcba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [AW-1:0]            rsp_addr_ff, rsp_addr_in;
   logic [pcba_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   // search and decode helpers
   logic [WORDS_PER_CPU-1:0] sum_iso;
   logic [WIDX_W-1:0]        sum_w;
   logic                     sum_found;
   logic [WW-1:0]            word_iso;
   logic [BW-1:0]            bit_b;
   logic [WW-1:0]            word_set;
   logic [IDX_W-1:0]         alloc_idx;
   logic                     alloc_ok;
   logic                     alloc_cpu_bad;
   logic [AW-1:0]            fcpu_wide;
   logic [CPU_REGION_SHIFT-1:0] slice_off, align_mask, widx;
   logic                     free_bad;
   logic [MEM_AW-1:0]        free_waddr;
   logic [31:0]              idx_ext;

   function automatic logic [MEM_AW-1:0] word_addr(input logic [SUM_AW-1:0] c,
                                                   input logic [WIDX_W-1:0] w);
      logic [31:0] a;
      a = 32'(c) * 32'(WORDS_PER_CPU) + 32'(w);
      return a[MEM_AW-1:0];
   endfunction

   // lowest zero of the summary word: the first word of this CPU that is not full
   always_comb begin
      sum_iso   = ~summary_rd_ff & (summary_rd_ff + WORDS_PER_CPU'(1));
      sum_found = ~&summary_rd_ff;
      sum_w     = '0;
      for (int j = 0; j < WORDS_PER_CPU; j++) begin
         if (sum_iso[j]) sum_w = sum_w | WIDX_W'(j);
      end
   end

   // lowest clear bit of the bitmap word
   always_comb begin
      word_iso = ~usage_rd_ff & (usage_rd_ff + WW'(1));
      bit_b    = '0;
      for (int j = 0; j < WW; j++) begin
         if (word_iso[j]) bit_b = bit_b | BW'(j);
      end
   end

   assign word_set      = usage_rd_ff | word_iso;
   assign alloc_idx     = {w_ff, bit_b};
   assign alloc_ok      = (32'(alloc_idx) < 32'(ENTRIES_PER_CPU)) && (|word_iso);
   assign alloc_cpu_bad = ({1'b0, cpu_ff} >= (pcba_pkg::CPU_W + 1)'(NUM_CPUS));

   // free address decode, works on the registered offset from the base
   assign fcpu_wide  = off_ff >> CPU_REGION_SHIFT;
   assign slice_off  = off_ff[CPU_REGION_SHIFT-1:0];
   assign align_mask = ~({CPU_REGION_SHIFT{1'b1}} << shift_ff);
   assign widx       = slice_off >> shift_ff;
   assign free_bad   = bad_ff
                    || (fcpu_wide >= AW'(NUM_CPUS))
                    || (|(slice_off & align_mask))
                    || (64'(widx) >= 64'(ENTRIES_PER_CPU));
   assign free_waddr = word_addr(cpu_ff[SUM_AW-1:0], idx_ff[IDX_W-1:BW]);

   assign idx_ext = 32'(idx_ff);

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      base_in       = base_ff;
      shift_in      = shift_ff;
      op_in         = op_ff;
      cpu_in        = cpu_ff;
      addr_in       = addr_ff;
      off_in        = off_ff;
      bad_in        = bad_ff;
      w_in          = w_ff;
      use_addr_in   = use_addr_ff;
      base_cpu_in   = base_cpu_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_index_in  = rsp_index_ff;

      usage_re      = 1'b0;
      usage_raddr   = '0;
      usage_we      = 1'b0;
      usage_waddr   = use_addr_ff;
      usage_wdata   = '0;
      summary_re    = 1'b0;
      summary_raddr = cpu_ff[SUM_AW-1:0];
      summary_we    = 1'b0;
      summary_waddr = cpu_ff[SUM_AW-1:0];
      summary_wdata = '0;

      if (csr_we) begin
         case (csr_index)
            pcba_pkg::CSR_REGION_BASE:  base_in  = csr_wdata;
            pcba_pkg::CSR_BUFFER_SHIFT: shift_in = csr_wdata[pcba_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         pcba_pkg::S_CLEAR: begin
            usage_we    = 1'b1;
            usage_waddr = clr_cnt_ff;
            if (32'(clr_cnt_ff) < 32'(NUM_CPUS)) begin
               summary_we    = 1'b1;
               summary_waddr = SUM_AW'(clr_cnt_ff);
            end
            clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
            if (clr_cnt_ff == MEM_AW'(TOTAL_WORDS - 1)) state_in = pcba_pkg::S_IDLE;
         end
         pcba_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               op_in   = req_bus.opcode;
               cpu_in  = req_bus.cpu;
               addr_in = req_bus.buffer_address;
               if (req_bus.opcode == pcba_pkg::OP_ALLOC) begin
                  summary_re    = 1'b1;
                  summary_raddr = req_bus.cpu[SUM_AW-1:0];
                  state_in      = pcba_pkg::S_ASUM;
               end else begin
                  state_in = pcba_pkg::S_FSUB;
               end
            end
         end
         pcba_pkg::S_ASUM: begin
            base_cpu_in = base_ff + (AW'(cpu_ff) << CPU_REGION_SHIFT);
            w_in        = sum_w;
            if (alloc_cpu_bad || !sum_found) begin
               status_in = pcba_pkg::STATUS_FULL;
               idx_in    = '0;
               state_in  = pcba_pkg::S_RESP;
            end else begin
               usage_re    = 1'b1;
               usage_raddr = word_addr(cpu_ff[SUM_AW-1:0], sum_w);
               use_addr_in = usage_raddr;
               state_in    = pcba_pkg::S_AWORD;
            end
         end
         pcba_pkg::S_AWORD: begin
            if (alloc_ok) begin
               usage_we    = 1'b1;
               usage_wdata = word_set;
               // word just became full: mark it in the summary
               if (&word_set) begin
                  summary_we    = 1'b1;
                  summary_wdata = summary_rd_ff | (WORDS_PER_CPU'(1) << w_ff);
               end
               idx_in    = alloc_idx;
               status_in = pcba_pkg::STATUS_OK;
            end else begin
               idx_in    = '0;
               status_in = pcba_pkg::STATUS_FULL;
            end
            state_in = pcba_pkg::S_RESP;
         end
         pcba_pkg::S_FSUB: begin
            off_in   = addr_ff - base_ff;
            bad_in   = addr_ff < base_ff;
            state_in = pcba_pkg::S_FDEC;
         end
         pcba_pkg::S_FDEC: begin
            bad_in   = free_bad;
            cpu_in   = fcpu_wide[pcba_pkg::CPU_W-1:0];
            idx_in   = IDX_W'(widx);
            state_in = pcba_pkg::S_FRD;
         end
         pcba_pkg::S_FRD: begin
            if (bad_ff) begin
               status_in = pcba_pkg::STATUS_BAD_ADDR;
               idx_in    = '0;
               state_in  = pcba_pkg::S_RESP;
            end else begin
               summary_re  = 1'b1;
               usage_re    = 1'b1;
               usage_raddr = free_waddr;
               use_addr_in = free_waddr;
               state_in    = pcba_pkg::S_FWR;
            end
         end
         pcba_pkg::S_FWR: begin
            usage_we      = 1'b1;
            usage_wdata   = usage_rd_ff & ~(WW'(1) << idx_ff[BW-1:0]);
            summary_we    = 1'b1;
            summary_wdata = summary_rd_ff & ~(WORDS_PER_CPU'(1) << idx_ff[IDX_W-1:BW]);
            status_in     = pcba_pkg::STATUS_OK;
            state_in      = pcba_pkg::S_RESP;
         end
         pcba_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = idx_ext[pcba_pkg::INDEX_W-1:0];
               if (op_ff == pcba_pkg::OP_ALLOC && status_ff == pcba_pkg::STATUS_OK)
                  rsp_addr_in = base_cpu_ff + (AW'(idx_ff) << shift_ff);
               else
                  rsp_addr_in = '0;
               state_in = pcba_pkg::S_IDLE;
            end
         end
         default: state_in = pcba_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcba_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         base_ff      <= '0;
         shift_ff     <= pcba_pkg::BUFFER_SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         base_ff      <= base_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cpu_ff        <= cpu_in;
      addr_ff       <= addr_in;
      off_ff        <= off_in;
      bad_ff        <= bad_in;
      w_ff          <= w_in;
      use_addr_ff   <= use_addr_in;
      base_cpu_ff   <= base_cpu_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_index_ff  <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (usage_we) usage_mem[usage_waddr] <= usage_wdata;
      if (usage_re) usage_rd_ff <= usage_mem[usage_raddr];
   end

   always_ff @(posedge clock) begin
      if (summary_we) summary_mem[summary_waddr] <= summary_wdata;
      if (summary_re) summary_rd_ff <= summary_mem[summary_raddr];
   end

   assign req_bus.ready           = (state_ff == pcba_pkg::S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.granted_address = rsp_addr_ff;
   assign rsp_bus.entry_index     = rsp_index_ff;

`ifndef SYNTHESIS
   // a failed request never reports an address or an index
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != pcba_pkg::STATUS_OK
      |-> rsp_bus.granted_address == '0 && rsp_bus.entry_index == '0)
      else $error("non-ok response carries address or index");

   // one request at a time: a taken request closes the input for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request accepted while another is in flight");

   // a successful allocate sets exactly one bit that was clear
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pcba_pkg::S_AWORD && alloc_ok
      |-> usage_we && $countones(usage_wdata) == $countones(usage_rd_ff) + 1)
      else $error("allocate write-back did not set exactly one bit");
`endif

endmodule
